FILE: sv/qvr_pkg.sv
// Shared types, widths and codes for the quaternion vector rotation block.
`default_nettype none

package qvr_pkg;

    // Input quaternion, Q2.14, and vectors with 12 fraction bits.
    localparam int QUAT_W      = 16;
    localparam int QUAT_FRAC   = 14;
    localparam int VEC_W       = 24;
    localparam int VEC_FRAC    = 12;

    // Matrix entries keep QUAT_FRAC fraction bits and range [-2, 2).
    localparam int ENT_W       = QUAT_FRAC + 2;

    // Gravity offset register.
    localparam int GRAV_W      = 23;
    localparam logic [GRAV_W-1:0] GRAV_RESET = 23'd37601;

    // Register stages from input word to output word.
    localparam int PIPE_DEPTH  = 4;
    localparam int CNT_W       = $clog2(PIPE_DEPTH + 1);

    // Stream word widths.
    localparam int S_TDATA_W   = 4 * QUAT_W + 3 * VEC_W;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 3 * VEC_W;
    localparam int M_TUSER_W   = 1;

    typedef logic [1:0] action_t;

    localparam action_t ACT_BODY_TO_NED      = 2'd0;
    localparam action_t ACT_BODY_TO_NED_GRAV = 2'd1;
    localparam action_t ACT_NED_TO_BODY      = 2'd2;

    typedef logic signed [QUAT_W-1:0] quat_elem_t;
    typedef logic signed [VEC_W-1:0]  vec_t;
    typedef logic signed [ENT_W-1:0]  entry_t;

    typedef struct packed {
        quat_elem_t z;
        quat_elem_t y;
        quat_elem_t x;
        quat_elem_t w;
    } quat_t;

    // Element 0 is the x component and sits in the lowest bits.
    typedef vec_t [2:0] vec3_t;

    // Row-major rotation matrix, element 3*row+col.
    typedef entry_t [8:0] matrix_t;

endpackage

`default_nettype wire

FILE: sv/qvr_matrix.sv
// Two pipeline stages that build the saturated rotation matrix from a quaternion.
`default_nettype none

module qvr_matrix (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire qvr_pkg::action_t in_action,
    input  wire qvr_pkg::quat_t   in_quat,
    input  wire qvr_pkg::vec3_t   in_vec,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output qvr_pkg::action_t      out_action,
    output qvr_pkg::vec3_t        out_vec,
    output qvr_pkg::matrix_t      out_matrix,
    output logic                  out_clip
);

    localparam int PROD_W = 2 * qvr_pkg::QUAT_W;
    localparam int RAW_W  = PROD_W + 4;
    localparam int QNT_W  = RAW_W - qvr_pkg::QUAT_FRAC;
    localparam logic signed [RAW_W-1:0] ONE_RAW  = RAW_W'(1) << (2 * qvr_pkg::QUAT_FRAC);
    localparam logic signed [RAW_W-1:0] HALF_RAW = RAW_W'(1) << (qvr_pkg::QUAT_FRAC - 1);

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [RAW_W-1:0]  raw_t;

    function automatic raw_t ext(input prod_t p);
        return {{(RAW_W - PROD_W){p[PROD_W-1]}}, p};
    endfunction

    // Stage 1: the nine quaternion products.
    logic             s1_valid_reg;
    logic             s1_ready;
    qvr_pkg::action_t s1_action_reg;
    qvr_pkg::vec3_t   s1_vec_reg;
    prod_t            xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;

    // Stage 2: rounded and saturated entries.
    logic             s2_valid_reg;
    logic             s2_ready;
    qvr_pkg::action_t s2_action_reg;
    qvr_pkg::vec3_t   s2_vec_reg;
    qvr_pkg::matrix_t s2_matrix_reg;
    logic             s2_clip_reg;

    raw_t             raw [9];
    qvr_pkg::matrix_t ent_next;
    logic [8:0]       ent_clip;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            s1_action_reg <= in_action;
            s1_vec_reg    <= in_vec;
            xx_reg        <= in_quat.x * in_quat.x;
            yy_reg        <= in_quat.y * in_quat.y;
            zz_reg        <= in_quat.z * in_quat.z;
            xy_reg        <= in_quat.x * in_quat.y;
            xz_reg        <= in_quat.x * in_quat.z;
            yz_reg        <= in_quat.y * in_quat.z;
            wx_reg        <= in_quat.w * in_quat.x;
            wy_reg        <= in_quat.w * in_quat.y;
            wz_reg        <= in_quat.w * in_quat.z;
        end
    end

    always_comb begin
        raw[0] = ONE_RAW - ((ext(yy_reg) + ext(zz_reg)) <<< 1);
        raw[1] = (ext(xy_reg) - ext(wz_reg)) <<< 1;
        raw[2] = (ext(xz_reg) + ext(wy_reg)) <<< 1;
        raw[3] = (ext(xy_reg) + ext(wz_reg)) <<< 1;
        raw[4] = ONE_RAW - ((ext(xx_reg) + ext(zz_reg)) <<< 1);
        raw[5] = (ext(yz_reg) - ext(wx_reg)) <<< 1;
        raw[6] = (ext(xz_reg) - ext(wy_reg)) <<< 1;
        raw[7] = (ext(yz_reg) + ext(wx_reg)) <<< 1;
        raw[8] = ONE_RAW - ((ext(xx_reg) + ext(yy_reg)) <<< 1);
    end

    // Round half up to the entry grid, then clip to [-2, 2).
    for (genvar k = 0; k < 9; k++) begin : g_entry
        raw_t                    rnd;
        logic signed [QNT_W-1:0] qnt;
        logic                    fits;

        assign rnd  = raw[k] + HALF_RAW;
        assign qnt  = rnd[RAW_W-1:qvr_pkg::QUAT_FRAC];
        assign fits = (qnt[QNT_W-1:qvr_pkg::ENT_W-1] == '0)
                   || (qnt[QNT_W-1:qvr_pkg::ENT_W-1] == '1);

        always_comb begin
            ent_clip[k] = !fits;
            if (fits) begin
                ent_next[k] = qnt[qvr_pkg::ENT_W-1:0];
            end else if (qnt[QNT_W-1]) begin
                ent_next[k] = {1'b1, {(qvr_pkg::ENT_W-1){1'b0}}};
            end else begin
                ent_next[k] = {1'b0, {(qvr_pkg::ENT_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_ready && s1_valid_reg) begin
            s2_action_reg <= s1_action_reg;
            s2_vec_reg    <= s1_vec_reg;
            s2_matrix_reg <= ent_next;
            s2_clip_reg   <= |ent_clip;
        end
    end

    assign out_valid  = s2_valid_reg;
    assign out_action = s2_action_reg;
    assign out_vec    = s2_vec_reg;
    assign out_matrix = s2_matrix_reg;
    assign out_clip   = s2_clip_reg;

endmodule

`default_nettype wire

FILE: sv/qvr_rotate.sv
// Two pipeline stages that multiply the vector by the matrix or its transpose.
`default_nettype none

module qvr_rotate (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic [qvr_pkg::GRAV_W-1:0] gravity,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire qvr_pkg::action_t           in_action,
    input  wire qvr_pkg::vec3_t             in_vec,
    input  wire qvr_pkg::matrix_t           in_matrix,
    input  wire logic                       in_clip,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output qvr_pkg::vec3_t                  out_vec,
    output logic                            out_sat
);

    localparam int MUL_W  = qvr_pkg::ENT_W + qvr_pkg::VEC_W;
    localparam int SUM_W  = MUL_W + 3;
    localparam int RND_W  = SUM_W - qvr_pkg::QUAT_FRAC;
    localparam int DIFF_W = RND_W + 1;
    localparam logic signed [SUM_W-1:0] HALF_SUM = SUM_W'(1) << (qvr_pkg::QUAT_FRAC - 1);

    typedef logic signed [MUL_W-1:0] mul_t;

    // Stage 3: nine entry-times-component products.
    logic             s3_valid_reg;
    logic             s3_ready;
    logic             s3_grav_reg;
    logic             s3_clip_reg;
    mul_t             prod_reg [9];

    // Stage 4: output word.
    logic             s4_valid_reg;
    logic             s4_ready;
    qvr_pkg::vec3_t   s4_vec_reg;
    logic             s4_sat_reg;

    qvr_pkg::vec3_t   res_next;
    logic [2:0]       res_clip;

    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign in_ready = s3_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_ready) begin
            s3_valid_reg <= in_valid;
        end
    end

    // The NED to body direction reads the matrix by columns.
    for (genvar i = 0; i < 3; i++) begin : g_row
        for (genvar j = 0; j < 3; j++) begin : g_col
            qvr_pkg::entry_t sel;

            assign sel = (in_action == qvr_pkg::ACT_NED_TO_BODY) ? in_matrix[3*j+i]
                                                                 : in_matrix[3*i+j];

            always_ff @(posedge aclk) begin
                if (s3_ready && in_valid) begin
                    prod_reg[3*i+j] <= sel * in_vec[j];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_ready && in_valid) begin
            s3_grav_reg <= (in_action == qvr_pkg::ACT_BODY_TO_NED_GRAV);
            s3_clip_reg <= in_clip;
        end
    end

    // Exact three-term sum, round half up, optional gravity, then clip.
    for (genvar i = 0; i < 3; i++) begin : g_out
        logic signed [SUM_W-1:0]  sum;
        logic signed [RND_W-1:0]  rnd;
        logic signed [DIFF_W-1:0] diff;
        logic                     fits;

        assign sum  = SUM_W'(prod_reg[3*i]) + SUM_W'(prod_reg[3*i+1])
                    + SUM_W'(prod_reg[3*i+2]) + HALF_SUM;
        assign rnd  = sum[SUM_W-1:qvr_pkg::QUAT_FRAC];
        assign diff = (i == 2 && s3_grav_reg)
                    ? DIFF_W'(rnd) - $signed({{(DIFF_W - qvr_pkg::GRAV_W){1'b0}}, gravity})
                    : DIFF_W'(rnd);
        assign fits = (diff[DIFF_W-1:qvr_pkg::VEC_W-1] == '0)
                   || (diff[DIFF_W-1:qvr_pkg::VEC_W-1] == '1);

        always_comb begin
            res_clip[i] = !fits;
            if (fits) begin
                res_next[i] = diff[qvr_pkg::VEC_W-1:0];
            end else if (diff[DIFF_W-1]) begin
                res_next[i] = {1'b1, {(qvr_pkg::VEC_W-1){1'b0}}};
            end else begin
                res_next[i] = {1'b0, {(qvr_pkg::VEC_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (s4_ready) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s4_ready && s3_valid_reg) begin
            s4_vec_reg <= res_next;
            s4_sat_reg <= s3_clip_reg || (|res_clip);
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_vec   = s4_vec_reg;
    assign out_sat   = s4_sat_reg;

endmodule

`default_nettype wire

FILE: sv/quaternion_vector_rotation.sv
// Top level of the quaternion vector rotation block: ports, gravity register, pipeline.
//
//  Channel   Direction  Contents
//  s_*       in         one quaternion, one vector and the action code per word
//  m_*       out        rotated vector and the saturation flag per word
//  cfg_*     in         write of the gravity offset register
//
// Four register stages: quaternion products, matrix entries, entry-times-component
// products, and the rounded, clipped output word. One word is accepted every cycle
// while s_tready is high. A word passes through the stages in order and m_tvalid
// rises once it is held in the output stage, where it waits for m_tready.
// A stage holds its word while the next one is full and stalled, empty stages keep
// filling, and s_tready drops only when all four are full. Reset clears the valid
// bits and loads the gravity offset with 9.18.
`default_nettype none

module quaternion_vector_rotation (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          cfg_wen,
    input  wire logic [qvr_pkg::GRAV_W-1:0]    cfg_wdata,   // gravity offset, Q11.12

    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z from bit 0 up
    input  wire logic [qvr_pkg::S_TDATA_W-1:0] s_tdata,
    // action
    input  wire logic [qvr_pkg::S_TUSER_W-1:0] s_tuser,

    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // out_x, out_y, out_z from bit 0 up
    output logic [qvr_pkg::M_TDATA_W-1:0]      m_tdata,
    // saturated
    output logic [qvr_pkg::M_TUSER_W-1:0]      m_tuser
);

    localparam int QB = 4 * qvr_pkg::QUAT_W;

    logic [qvr_pkg::GRAV_W-1:0] gravity_reg;

    qvr_pkg::quat_t   in_quat;
    qvr_pkg::vec3_t   in_vec;

    logic             mid_valid;
    logic             mid_ready;
    qvr_pkg::action_t mid_action;
    qvr_pkg::vec3_t   mid_vec;
    qvr_pkg::matrix_t mid_matrix;
    logic             mid_clip;

    qvr_pkg::vec3_t   res_vec;
    logic             res_sat;

    // Gravity offset; the user must write it only while the block is idle, the block does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gravity_reg <= qvr_pkg::GRAV_RESET;
        end else if (cfg_wen) begin
            gravity_reg <= cfg_wdata;
        end
    end

    // The quaternion occupies the low bits of the word and the vector the rest.
    assign in_quat = s_tdata[QB-1:0];
    assign in_vec  = s_tdata[qvr_pkg::S_TDATA_W-1:QB];

    qvr_matrix u_matrix (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_action  (s_tuser),
        .in_quat    (in_quat),
        .in_vec     (in_vec),
        .out_valid  (mid_valid),
        .out_ready  (mid_ready),
        .out_action (mid_action),
        .out_vec    (mid_vec),
        .out_matrix (mid_matrix),
        .out_clip   (mid_clip)
    );

    qvr_rotate u_rotate (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .gravity    (gravity_reg),
        .in_valid   (mid_valid),
        .in_ready   (mid_ready),
        .in_action  (mid_action),
        .in_vec     (mid_vec),
        .in_matrix  (mid_matrix),
        .in_clip    (mid_clip),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_vec    (res_vec),
        .out_sat    (res_sat)
    );

    assign m_tdata = res_vec;
    assign m_tuser = res_sat;

    // Words inside the pipeline, kept for the checks below.
    logic [qvr_pkg::CNT_W-1:0] inflight_reg;
    logic [qvr_pkg::CNT_W-1:0] inflight_next;

    always_comb begin
        inflight_next = inflight_reg;
        if (s_tvalid && s_tready) begin
            inflight_next = inflight_next + qvr_pkg::CNT_W'(1);
        end
        if (m_tvalid && m_tready) begin
            inflight_next = inflight_next - qvr_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // The pipeline never holds more words than it has stages.
    a_inflight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= qvr_pkg::CNT_W'(qvr_pkg::PIPE_DEPTH))
        else $error("more words in flight than pipeline stages");

    // A result is offered only for a word that went in.
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> inflight_reg != '0)
        else $error("output valid with an empty pipeline");

    // The input stalls only behind a stalled output word.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready
                       && inflight_reg == qvr_pkg::CNT_W'(qvr_pkg::PIPE_DEPTH)))
        else $error("input stalled while the pipeline has room");

endmodule

`default_nettype wire
